>>> hw/rtl/infix_expression_evaluator_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the evaluator's top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Assert that a property holds on every clock edge outside reset.
`define IEE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a property holds on every clock edge, reset included.
`define IEE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/iee_pkg.sv
// ---------------------------------------------------------------------------
// iee_pkg
// Shared widths, operator codes and status codes of the infix evaluator.
// ---------------------------------------------------------------------------
`default_nettype none
package iee_pkg;
    localparam int DATA_WIDTH     = 32;
    localparam int VALUE_DEPTH    = 16;
    localparam int OPERATOR_DEPTH = 16;
    localparam int VAW = $clog2(VALUE_DEPTH);
    localparam int OAW = $clog2(OPERATOR_DEPTH);
    localparam int DIV_CW = $clog2(DATA_WIDTH + 1);

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [VAW:0]          t_vcount;
    typedef logic [OAW:0]          t_ocount;
    typedef logic [2:0]            t_op;
    typedef logic [1:0]            t_status;

    localparam t_op OP_ADD  = 3'd0;
    localparam t_op OP_SUB  = 3'd1;
    localparam t_op OP_MUL  = 3'd2;
    localparam t_op OP_DIV  = 3'd3;
    localparam t_op OP_OPEN = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_DIVZERO   = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;
    localparam t_status ST_MALFORMED = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Request to and reply from the shared arithmetic unit.
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic divzero;
    } t_alu_rsp;

    // Binding strength of an operator code; the open bracket binds least.
    function automatic logic [1:0] prec(input t_op op);
        logic [1:0] p;
        p = 2'd0;
        if (op == OP_ADD || op == OP_SUB) p = 2'd1;
        if (op == OP_MUL || op == OP_DIV) p = 2'd2;
        return p;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/iee_ram.sv
// ---------------------------------------------------------------------------
// iee_ram
// Generic RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/iee_alu.sv
// ---------------------------------------------------------------------------
// iee_alu
// Shared arithmetic unit: add, subtract and multiply done in the cycle after start,
// signed division by restoring shift-subtract, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module iee_alu
    import iee_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_alu_req i_req,
    input  t_data    i_a,
    input  t_data    i_b,
    output t_alu_rsp o_rsp,
    output t_data    o_result
);
    logic              r_busy;
    logic              r_done;
    logic              r_divzero;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_neg;
    t_data             r_rem;
    t_data             r_quo;
    t_data             r_div;
    t_data             r_res;
    t_data             mag_a;
    t_data             mag_b;
    logic [DATA_WIDTH:0] trial;

    assign mag_a = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    assign trial = {r_rem, r_quo[DATA_WIDTH-1]} - {1'b0, r_div};

    // Operation sequencing and the division iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_divzero <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_done    <= 1'b0;
            r_divzero <= 1'b0;
            if (i_req.start) begin
                case (i_req.op)
                    OP_ADD: begin
                        r_res  <= i_a + i_b;
                        r_done <= 1'b1;
                    end
                    OP_SUB: begin
                        r_res  <= i_a - i_b;
                        r_done <= 1'b1;
                    end
                    OP_MUL: begin
                        r_res  <= i_a * i_b;
                        r_done <= 1'b1;
                    end
                    default: begin
                        if (i_b == '0) begin
                            r_done    <= 1'b1;
                            r_divzero <= 1'b1;
                        end else begin
                            r_busy <= 1'b1;
                            r_cnt  <= DIV_CW'(DATA_WIDTH);
                            r_neg  <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
                            r_rem  <= '0;
                            r_quo  <= mag_a;
                            r_div  <= mag_b;
                        end
                    end
                endcase
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= r_neg ? (~r_quo + 1'b1) : r_quo;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                    if (!trial[DATA_WIDTH]) begin
                        r_rem <= trial[DATA_WIDTH-1:0];
                        r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[DATA_WIDTH-2:0], r_quo[DATA_WIDTH-1]};
                        r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.divzero = r_divzero;
    assign o_result      = r_res;
endmodule
`default_nettype wire

>>> hw/rtl/infix_expression_evaluator.sv
// A digit is only accumulated; a space, bracket or operator is decoded against the
// operator stack, after the number it closes is pushed; each operator applied runs on the
// shared unit (add, subtract, multiply) or on its shift-subtract divider (division).
// The last character adds a drain pass and the result output,
// plus any wait for the receiver. One request at a time; not ready while it works.
// Synchronous active-low reset empties both stacks; stack contents are not cleared.
// ---------------------------------------------------------------------------
// infix_expression_evaluator
// Two-stack infix evaluator with a sequencer around a shared arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none
`include "infix_expression_evaluator_defines.svh"
module infix_expression_evaluator
    import iee_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_char_code,
    input  wire         i_is_last,
    output logic        o_valid,
    input  wire         i_ready,
    output logic signed [31:0] o_result_value,
    output logic [1:0]  o_status
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHAR  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_RDA   = 4'd4;
    localparam logic [3:0] S_RDB   = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_WAIT  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_RES   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_PUSHN = 4'd11;

    logic [3:0] r_state, n_state;
    logic [7:0] r_ch;
    logic       r_last;
    t_vcount    r_vcnt;
    t_ocount    r_ocnt;
    t_data      r_acc;
    logic       r_innum;
    t_status    r_err;
    t_data      r_a;
    t_data      r_b;
    t_op        r_op;
    logic       r_final;
    logic       r_pend;

    // Stack memory ports.
    logic          v_we, o_we;
    logic [VAW-1:0] v_wa, v_ra;
    logic [OAW-1:0] o_wa, o_ra;
    t_data         v_wd, v_rd;
    t_op           o_wd, o_rd;
    t_alu_req      alu_req;
    t_alu_rsp      alu_rsp;
    t_data         alu_res;

    logic is_digit, is_op;
    t_op  ch_op;
    t_data acc_next;

    iee_ram #(.WIDTH(DATA_WIDTH), .DEPTH(VALUE_DEPTH)) u_vstack (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd));

    iee_ram #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_ostack (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_wa), .i_wdata(o_wd),
        .i_raddr(o_ra), .o_rdata(o_rd));

    iee_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(alu_req),
        .i_a(r_a), .i_b(r_b), .o_rsp(alu_rsp), .o_result(alu_res));

    // Character decode.
    assign is_digit = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign acc_next = (r_acc << 3) + (r_acc << 1) + t_data'(r_ch - CH_ZERO);
    always_comb begin
        is_op = 1'b1;
        ch_op = OP_ADD;
        case (r_ch)
            CH_PLUS:  ch_op = OP_ADD;
            CH_MINUS: ch_op = OP_SUB;
            CH_STAR:  ch_op = OP_MUL;
            CH_SLASH: ch_op = OP_DIV;
            default:  is_op = 1'b0;
        endcase
    end

    // Memory addressing.
    always_comb begin
        v_we = 1'b0;
        v_wa = r_vcnt[VAW-1:0];
        v_wd = r_acc;
        v_ra = r_vcnt[VAW-1:0] - 1'b1;
        o_we = 1'b0;
        o_wa = r_ocnt[OAW-1:0];
        o_wd = ch_op;
        o_ra = r_ocnt[OAW-1:0] - 1'b1;
        alu_req.start = 1'b0;
        alu_req.op    = r_op;
        case (r_state)
            S_PUSHN: v_we = (r_vcnt != t_vcount'(VALUE_DEPTH));
            S_RDA:   v_ra = r_vcnt[VAW-1:0] - 2'd2;
            S_RDB:   v_ra = r_vcnt[VAW-1:0] - 1'b1;
            S_EXEC:  alu_req.start = 1'b1;
            S_WAIT: begin
                v_wa = r_vcnt[VAW-1:0];
                v_wd = alu_res;
                v_we = alu_rsp.done && !alu_rsp.divzero;
            end
            S_CHAR: begin
                o_we = 1'b0;
            end
            S_DEC: begin
                o_wd = (r_ch == CH_OPEN) ? OP_OPEN : ch_op;
                o_we = (r_err == ST_OK) && (r_ocnt != t_ocount'(OPERATOR_DEPTH))
                    && !r_final && ((r_ch == CH_OPEN) || (is_op && (r_ocnt == '0
                    || o_rd == OP_OPEN || prec(o_rd) < prec(ch_op))));
            end
            S_FIN:   v_ra = '0;
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt  <= '0;
            r_ocnt  <= '0;
            r_acc   <= '0;
            r_innum <= 1'b0;
            r_err   <= ST_OK;
            r_final <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ch    <= i_char_code;
                        r_last  <= i_is_last;
                        r_final <= 1'b0;
                    end
                end
                S_CHAR: begin
                    if (r_err == ST_OK && is_digit && !r_final) begin
                        r_acc   <= acc_next;
                        r_innum <= 1'b1;
                    end
                end
                S_PUSHN: begin
                    if (r_vcnt == t_vcount'(VALUE_DEPTH)) begin
                        r_err <= ST_OVERFLOW;
                    end else begin
                        r_vcnt <= r_vcnt + 1'b1;
                    end
                    r_acc   <= '0;
                    r_innum <= 1'b0;
                end
                S_RD: ;
                S_DEC: begin
                    r_op <= o_rd;
                    if (r_err != ST_OK) begin
                        // Nothing more to do for this character.
                    end else if (r_final) begin
                        if (r_ocnt == '0) begin
                            if (r_vcnt != t_vcount'(1)) r_err <= ST_MALFORMED;
                        end else if (o_rd == OP_OPEN) begin
                            r_err <= ST_MALFORMED;
                        end else begin
                            r_ocnt <= r_ocnt - 1'b1;
                        end
                    end else if (r_ch == CH_OPEN) begin
                        if (r_ocnt == t_ocount'(OPERATOR_DEPTH)) r_err <= ST_OVERFLOW;
                        else r_ocnt <= r_ocnt + 1'b1;
                    end else if (r_ch == CH_CLOSE) begin
                        if (r_ocnt == '0) r_err <= ST_MALFORMED;
                        else r_ocnt <= r_ocnt - 1'b1;
                    end else if (is_op) begin
                        if (r_ocnt == '0 || o_rd == OP_OPEN
                            || prec(o_rd) < prec(ch_op)) begin
                            if (r_ocnt == t_ocount'(OPERATOR_DEPTH)) r_err <= ST_OVERFLOW;
                            else r_ocnt <= r_ocnt + 1'b1;
                        end else begin
                            r_ocnt <= r_ocnt - 1'b1;
                        end
                    end else if (r_ch != CH_SPACE) begin
                        r_err <= ST_MALFORMED;
                    end
                end
                S_RDA: begin
                    r_b <= v_rd;
                    if (r_vcnt < t_vcount'(2)) begin
                        r_err <= ST_MALFORMED;
                    end else begin
                        r_vcnt <= r_vcnt - 1'b1;
                    end
                end
                S_RDB: begin
                    r_a    <= v_rd;
                    r_vcnt <= r_vcnt - 1'b1;
                end
                S_EXEC: ;
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        if (alu_rsp.divzero) r_err <= ST_DIVZERO;
                        else r_vcnt <= r_vcnt + 1'b1;
                    end
                end
                S_FIN: begin
                    r_pend <= 1'b1;
                end
                S_RES: ;
                S_OUT: begin
                    if (i_ready) begin
                        r_vcnt  <= '0;
                        r_ocnt  <= '0;
                        r_acc   <= '0;
                        r_innum <= 1'b0;
                        r_err   <= ST_OK;
                        r_pend  <= 1'b0;
                    end
                end
                default: ;
            endcase
            if (r_state == S_CHAR && r_last && is_digit) r_final <= 1'b1;
            if (r_state == S_DEC && r_last && !r_final &&
                (n_state == S_RD || n_state == S_FIN)) r_final <= 1'b1;
        end
    end

    // Where a character leads next: the operator stack is read, one operator
    // is applied, and the decision is repeated until the character settles.
    logic dec_apply;
    always_comb begin
        dec_apply = 1'b0;
        if (r_err == ST_OK) begin
            if (r_final) begin
                dec_apply = (r_ocnt != '0) && (o_rd != OP_OPEN);
            end else if (r_ch == CH_CLOSE) begin
                dec_apply = (r_ocnt != '0) && (o_rd != OP_OPEN);
            end else if (is_op) begin
                dec_apply = (r_ocnt != '0) && (o_rd != OP_OPEN)
                    && (prec(o_rd) >= prec(ch_op));
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CHAR;
            S_CHAR: begin
                if (r_err != ST_OK) n_state = r_last ? S_FIN : S_IDLE;
                else if (is_digit) n_state = r_last ? S_RD : S_IDLE;
                else if (r_innum) n_state = S_PUSHN;
                else n_state = S_RD;
                if (r_err == ST_OK && is_digit && r_last) n_state = S_PUSHN;
            end
            S_PUSHN: n_state = S_RD;
            S_RD:    n_state = S_DEC;
            S_DEC: begin
                if (dec_apply) n_state = S_RDA;
                else if (r_final || r_err != ST_OK || !r_last) begin
                    n_state = (r_final || r_last) ? S_FIN : S_IDLE;
                end else n_state = S_RD;
            end
            S_RDA:   n_state = (r_vcnt < t_vcount'(2)) ? S_RD : S_RDB;
            S_RDB:   n_state = S_EXEC;
            S_EXEC:  n_state = S_WAIT;
            S_WAIT:  if (alu_rsp.done) n_state = S_RD;
            S_FIN:   n_state = S_RES;
            S_RES:   n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Result register, loaded from the bottom of the value stack, or zero on an error status.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RES) begin
            o_result_value <= (r_err == ST_OK) ? v_rd : '0;
            o_status       <= r_err;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    `IEE_ASSERT(a_vcnt_range, i_clk, i_rst_n, r_vcnt <= t_vcount'(VALUE_DEPTH), "value count beyond depth")
    `IEE_ASSERT(a_ocnt_range, i_clk, i_rst_n, r_ocnt <= t_ocount'(OPERATOR_DEPTH), "operator count beyond depth")
    `IEE_ASSERT(a_out_pend, i_clk, i_rst_n, o_valid |-> r_pend, "result shown without a finished expression")
    `IEE_ASSERT(a_excl, i_clk, i_rst_n, !(o_ready && o_valid), "ready and result together")
endmodule
`default_nettype wire

>>> tb/sv/infix_expression_evaluator_tb.sv
// ---------------------------------------------------------------------------
// infix_expression_evaluator_tb
// Sends expressions one character per request and checks every value and
// status the evaluator returns against a cycle-free model or a directed row's typed answer.
// ---------------------------------------------------------------------------
`default_nettype none
module infix_expression_evaluator_tb
    import iee_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_char_code;
    logic        i_is_last;
    logic        o_valid;
    logic        i_ready;
    logic signed [31:0] o_result_value;
    logic [1:0]  o_status;

    infix_expression_evaluator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    typedef struct {
        logic [31:0] value;
        t_status     status;
    } t_answer;

    // One directed expression; a typed row carries its answer by hand.
    typedef struct {
        string       text;
        bit          typed;
        logic [31:0] value;
        t_status     status;
    } t_row;

    t_answer     answers_due[$];
    int          failures;
    int          chars_sent;
    int          idle_pct;
    int          stall_pct;
    int          hold_left;

    // Evaluator state as the model sees it.
    t_data       vals[VALUE_DEPTH];
    int          nvals;
    t_op         ops[OPERATOR_DEPTH];
    int          nops;
    t_data       accum;
    bit          in_digits;
    t_status     err;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void clear_model();
        nvals = 0;
        nops = 0;
        accum = '0;
        in_digits = 1'b0;
        err = ST_OK;
    endfunction

    function automatic void flag(t_status code);
        if (err == ST_OK) err = code;
    endfunction

    function automatic int strength(t_op op);
        if (op == OP_ADD || op == OP_SUB) return 1;
        if (op == OP_MUL || op == OP_DIV) return 2;
        return 0;
    endfunction

    function automatic void push_val(t_data v);
        if (nvals >= VALUE_DEPTH) begin
            flag(ST_OVERFLOW);
            return;
        end
        vals[nvals] = v;
        nvals++;
    endfunction

    function automatic void push_opcode(t_op op);
        if (nops >= OPERATOR_DEPTH) begin
            flag(ST_OVERFLOW);
            return;
        end
        ops[nops] = op;
        nops++;
    endfunction

    // Pops one operator and its two operands and pushes the outcome.
    function automatic void reduce_top();
        t_op         op;
        logic [31:0] a, b, r, ma, mb;
        op = ops[nops-1];
        nops--;
        if (nvals < 2) begin
            flag(ST_MALFORMED);
            return;
        end
        b = vals[nvals-1];
        a = vals[nvals-2];
        nvals -= 2;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            default: begin
                if (b == 0) begin
                    flag(ST_DIVZERO);
                    return;
                end
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                r = ma / mb;
                if (a[31] != b[31]) r = -r;
            end
        endcase
        push_val(r);
    endfunction

    function automatic void close_number();
        if (in_digits) begin
            push_val(accum);
            accum = '0;
            in_digits = 1'b0;
        end
    endfunction

    function automatic void take(logic [7:0] c);
        t_op op;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            accum = accum * 10 + (c - CH_ZERO);
            in_digits = 1'b1;
            return;
        end
        close_number();
        if (err != ST_OK || c == CH_SPACE) return;
        if (c == CH_OPEN) begin
            push_opcode(OP_OPEN);
            return;
        end
        if (c == CH_CLOSE) begin
            while (nops > 0 && err == ST_OK && ops[nops-1] != OP_OPEN) reduce_top();
            if (err != ST_OK) return;
            if (nops == 0) flag(ST_MALFORMED);
            else nops--;
            return;
        end
        case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default: begin
                flag(ST_MALFORMED);
                return;
            end
        endcase
        while (nops > 0 && err == ST_OK && ops[nops-1] != OP_OPEN &&
               strength(ops[nops-1]) >= strength(op)) reduce_top();
        if (err == ST_OK) push_opcode(op);
    endfunction

    // Advances the model by one character; returns 1 when an answer is due.
    function automatic bit evaluate(logic [7:0] c, bit last, output t_answer ans);
        if (err == ST_OK) take(c);
        if (!last) return 1'b0;
        if (err == ST_OK) close_number();
        while (err == ST_OK && nops > 0) begin
            if (ops[nops-1] == OP_OPEN) flag(ST_MALFORMED);
            else reduce_top();
        end
        if (err == ST_OK && nvals != 1) flag(ST_MALFORMED);
        ans.status = err;
        ans.value = (err == ST_OK) ? vals[0] : '0;
        clear_model();
        return 1'b1;
    endfunction

    // Offers one character and waits for the request to be taken.
    task automatic send_char(logic [7:0] c, bit last, bit typed, t_answer fixed);
        t_answer ans;
        i_valid <= 1'b1;
        i_char_code <= c;
        i_is_last <= last;
        do @(posedge i_clk); while (!o_ready);
        chars_sent++;
        if (evaluate(c, last, ans)) answers_due.push_back(typed ? fixed : ans);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Sends a whole expression; '@' stands for a NUL character.
    task automatic send_text(string s, bit typed, t_answer fixed, bit noisy);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = (s[i] == "@") ? 8'h00 : s[i];
            if (noisy && $urandom_range(99) < 3) c = $urandom_range(255);
            send_char(c, i == s.len() - 1, typed, fixed);
        end
    endtask

    // Random number text: mostly small, sometimes full width or zero.
    function automatic string gen_number();
        case ($urandom_range(9))
            0: return "0";
            1, 2: return $sformatf("%0d", $urandom);
            default: return $sformatf("%0d", $urandom_range(99));
        endcase
    endfunction

    function automatic string gen_space();
        return ($urandom_range(9) == 0) ? " " : "";
    endfunction

    // Well-formed expression with random content and bracket nesting.
    function automatic string gen_expr(int depth);
        string s, opch;
        int    terms;
        terms = $urandom_range(1, 4);
        s = "";
        for (int t = 0; t < terms; t++) begin
            if (t > 0) begin
                case ($urandom_range(3))
                    0: opch = "+";
                    1: opch = "-";
                    2: opch = "*";
                    default: opch = "/";
                endcase
                s = {s, gen_space(), opch, gen_space()};
            end
            if (depth < 3 && $urandom_range(3) == 0)
                s = {s, "(", gen_expr(depth + 1), ")"};
            else
                s = {s, gen_number()};
        end
        return s;
    endfunction

    // Mostly well-formed expressions, some broken on purpose.
    function automatic string gen_case();
        string s;
        s = gen_expr(0);
        case ($urandom_range(19))
            0: s = {"-", s};
            1: s = {s, "+"};
            2: s = {"(", s};
            3: s = {s, ")"};
            4: s = {s, " "};
            5: begin
                for (int i = $urandom_range(14, 18); i > 0; i--) s = {"(", s};
            end
            6: begin
                for (int i = $urandom_range(6, 9); i > 0; i--) s = {"1+(", s};
            end
            default: ;
        endcase
        return s;
    endfunction

    // Result side: random stalls, long hold-offs, and the answer check.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (answers_due.size() == 0) begin
                $error("result with no request waiting for one");
                failures++;
            end else begin
                want = answers_due.pop_front();
                if (o_result_value !== want.value) begin
                    $error("result_value expected %0d actual %0d",
                           $signed(want.value), o_result_value);
                    failures++;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    failures++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    t_row rows[] = '{
        '{"7", 1, 32'd7, ST_OK},
        '{"12+34", 1, 32'd46, ST_OK},
        '{"9-20", 1, -32'sd11, ST_OK},
        '{"2+3*4", 1, 32'd14, ST_OK},
        '{"(1+2)*3", 1, 32'd9, ST_OK},
        '{"(0-7)/2", 1, -32'sd3, ST_OK},
        '{"4294967299", 1, 32'd3, ST_OK},
        '{"2147483648/(0-1)", 1, 32'h8000_0000, ST_OK},
        '{"5/0", 1, 32'd0, ST_DIVZERO},
        '{"1\377", 1, 32'd0, ST_MALFORMED},
        '{"@", 1, 32'd0, ST_MALFORMED},
        '{"(1", 1, 32'd0, ST_MALFORMED},
        '{"1)", 1, 32'd0, ST_MALFORMED},
        '{" ", 1, 32'd0, ST_MALFORMED},
        '{"1 2", 1, 32'd0, ST_MALFORMED},
        '{"-4", 1, 32'd0, ST_MALFORMED},
        '{{"((((((((((", "(((((((", "1"}, 1, 32'd0, ST_OVERFLOW},
        '{"8/3 - 6 * 2", 0, 32'd0, ST_OK}
    };

    // Main sequence.
    initial begin
        t_answer fixed;
        int      spins;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_char_code = '0;
        i_is_last = 1'b0;
        failures = 0;
        chars_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        clear_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed expressions.
        foreach (rows[i]) begin
            fixed.value = rows[i].value;
            fixed.status = rows[i].status;
            send_text(rows[i].text, rows[i].typed, fixed, 1'b0);
        end

        // Random expressions over the idling phases.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                3: begin idle_pct = 18; stall_pct = 18; end
                default: begin idle_pct = 0; stall_pct = 0; hold_left = 400; end
            endcase
            while (chars_sent < 370 * (phase + 1))
                send_text(gen_case(), 1'b0, fixed, 1'b1);
            // Sender pauses until every answer is in or the wait limit runs out.
            i_valid <= 1'b0;
            spins = 0;
            while (answers_due.size() != 0 && spins < 200000) begin
                @(posedge i_clk);
                spins++;
            end
        end

        repeat (200) @(posedge i_clk);
        if (failures == 0 && answers_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (answers_due.size() != 0) $error("%0d results never arrived", answers_due.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/iee_pkg.sv
hw/rtl/iee_ram.sv
hw/rtl/iee_alu.sv
hw/rtl/infix_expression_evaluator.sv
tb/sv/infix_expression_evaluator_tb.sv
